>>> src/asc_pkg.sv
`timescale 1ns / 1ps
package asc_pkg;

	localparam int NUM_CLASSES = 128;
	localparam int IDX_W = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
	localparam int CNT_W = $clog2(NUM_CLASSES + 1);
	localparam int SCORE_W = 16;
	localparam int TERM_W = 17;
	localparam int SUM_W = IDX_W + TERM_W;
	localparam int EXP_BITS = 12;
	localparam int EXP_CNT_W = $clog2(EXP_BITS);
	localparam int DIV_STEPS = 33;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam int OUT_W = 40;
	localparam logic [63:0] EXP_BASE_Q32 = 64'd4278222805;
	localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
	localparam logic [9:0] PERCENT_MAX = 10'd100;
	localparam logic [9:0] DECIMAL_OFFSET = 10'd111;
	localparam logic [9:0] READING_MAX = 10'd127;

	function automatic logic [31:0] exp_factor(input int b);
		logic [63:0] f;
		f = EXP_BASE_Q32;
		for (int i = 0; i < b; i++) begin
			f = (f * f + HALF_Q32) >> 32;
		end
		return f[31:0];
	endfunction

	localparam logic [31:0] EXP_FACT [EXP_BITS] = '{
		exp_factor(0), exp_factor(1), exp_factor(2), exp_factor(3),
		exp_factor(4), exp_factor(5), exp_factor(6), exp_factor(7),
		exp_factor(8), exp_factor(9), exp_factor(10), exp_factor(11)
	};

	typedef struct packed {
		logic                      we;
		logic [IDX_W-1:0]          waddr;
		logic signed [SCORE_W-1:0] wdata;
		logic                      re;
		logic [IDX_W-1:0]          raddr;
	} ram_req_t;

endpackage

>>> src/asc_score_store.sv
`timescale 1ns / 1ps
module asc_score_store (
	input  logic                              clk,
	input  asc_pkg::ram_req_t                 req,
	output logic signed [asc_pkg::SCORE_W-1:0] rd_data
);

	logic signed [asc_pkg::SCORE_W-1:0] mem [asc_pkg::NUM_CLASSES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

>>> src/asc_exp_unit.sv
`timescale 1ns / 1ps
module asc_exp_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [15:0]                   k,
	output logic                          done,
	output logic [asc_pkg::TERM_W-1:0]    term
);

	logic [asc_pkg::EXP_BITS-1:0]  k_q;
	logic                          big_q;
	logic                          one_q;
	logic [31:0]                   acc_q;
	logic [asc_pkg::EXP_CNT_W-1:0] bit_q;
	logic                          busy_q;
	logic                          done_q;
	logic [31:0]                   fact;
	logic [63:0]                   prod;
	logic [63:0]                   prod_rnd;
	logic [32:0]                   acc_full;
	logic [32:0]                   acc_rnd;

	assign fact = asc_pkg::EXP_FACT[bit_q];
	assign prod = 64'(acc_q) * 64'(fact);
	assign prod_rnd = prod + asc_pkg::HALF_Q32;
	assign acc_full = one_q ? 33'h1_0000_0000 : {1'b0, acc_q};
	assign acc_rnd = acc_full + 33'd32768;
	assign term = big_q ? '0 : acc_rnd[32:16];
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q <= '0;
			end else if (busy_q) begin
				if (bit_q == asc_pkg::EXP_CNT_W'(asc_pkg::EXP_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q + 1'b1;
				end
			end
		end
	end

	// While the product is still exactly one, a multiply just yields the factor.
	always_ff @(posedge clk) begin
		if (start) begin
			k_q <= k[asc_pkg::EXP_BITS-1:0];
			big_q <= |k[15:asc_pkg::EXP_BITS];
			one_q <= 1'b1;
			acc_q <= '0;
		end else if (busy_q && k_q[bit_q]) begin
			one_q <= 1'b0;
			acc_q <= one_q ? fact : prod_rnd[63:32];
		end
	end

endmodule

>>> src/asc_divider.sv
`timescale 1ns / 1ps
module asc_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [asc_pkg::SUM_W-1:0]  den,
	output logic                       done,
	output logic [15:0]                conf
);

	logic [32:0]                   num_q;
	logic [asc_pkg::SUM_W-1:0]     rem_q;
	logic [asc_pkg::SUM_W-1:0]     den_q;
	logic [asc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [asc_pkg::SUM_W:0]       trial;
	logic                          qbit;

	assign trial = {rem_q, num_q[32]};
	assign qbit = trial >= {1'b0, den_q};
	assign done = done_q;
	assign conf = (|num_q[32:16]) ? 16'hFFFF : num_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == asc_pkg::DIV_CNT_W'(asc_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Restoring division of 2^32 plus half the sum; quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			num_q <= 33'h1_0000_0000 + 33'(den >> 1);
		end else if (busy_q) begin
			rem_q <= qbit ? asc_pkg::SUM_W'(trial - {1'b0, den_q})
				: trial[asc_pkg::SUM_W-1:0];
			num_q <= {num_q[31:0], qbit};
		end
	end

endmodule

>>> src/argmax_softmax_confidence.sv
`timescale 1ns / 1ps
// Scores are taken one per cycle while a vector loads.
// After the request carrying tlast, each stored score passes through a store read (ST_READ),
// a set-up state (ST_START) and the serial exponential unit (ST_TERM); then the sum is divided.
// No score is taken between the last request and the result.
// Reset clears the control state and the running maximum; the score store is not cleared.
module argmax_softmax_confidence (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // logit
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // class_index, confidence, is_decimal, reading, overflow
);

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_TERM  = 3'd3;
	localparam logic [2:0] ST_DIVGO = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                          state_q;
	logic [asc_pkg::CNT_W-1:0]           count_q;
	logic signed [asc_pkg::SCORE_W-1:0]  best_q;
	logic [asc_pkg::IDX_W-1:0]           best_idx_q;
	logic                                drop_q;
	logic [asc_pkg::CNT_W-1:0]           rd_idx_q;
	logic [asc_pkg::SUM_W-1:0]           sum_q;
	logic [15:0]                         conf_q;
	logic                                m_tvalid_q;
	logic [39:0]                         m_tdata_q;

	asc_pkg::ram_req_t                   ram_req;
	logic signed [asc_pkg::SCORE_W-1:0]  rd_data;
	logic signed [asc_pkg::SCORE_W-1:0]  logit;
	logic                                accept;
	logic                                full;
	logic [16:0]                         k_wide;
	logic                                exp_done;
	logic [asc_pkg::TERM_W-1:0]          term;
	logic                                div_done;
	logic [15:0]                         div_conf;
	logic                                out_free;
	logic [7:0]                          idx8;
	logic                                is_dec;
	logic [9:0]                          dec_wide;
	logic [7:0]                          reading;

	assign logit = s_tdata;
	assign s_tready = (state_q == ST_LOAD);
	assign accept = s_tvalid && s_tready;
	assign full = (count_q == asc_pkg::CNT_W'(asc_pkg::NUM_CLASSES));
	assign out_free = !m_tvalid_q || m_tready;

	assign ram_req.we = accept && !full;
	assign ram_req.waddr = count_q[asc_pkg::IDX_W-1:0];
	assign ram_req.wdata = logit;
	assign ram_req.re = (state_q == ST_READ);
	assign ram_req.raddr = rd_idx_q[asc_pkg::IDX_W-1:0];

	assign k_wide = {best_q[15], best_q} - {rd_data[15], rd_data};

	asc_score_store u_store (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	asc_exp_unit u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.k      (k_wide[15:0]),
		.done   (exp_done),
		.term   (term)
	);

	asc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIVGO),
		.den    (sum_q),
		.done   (div_done),
		.conf   (div_conf)
	);

	assign idx8 = 8'(best_idx_q);
	assign is_dec = {2'b00, idx8} > asc_pkg::PERCENT_MAX;
	assign dec_wide = {2'b00, idx8} - asc_pkg::DECIMAL_OFFSET;
	always_comb begin
		if (!is_dec) begin
			reading = idx8;
		end else if (!dec_wide[9] && dec_wide > asc_pkg::READING_MAX) begin
			reading = asc_pkg::READING_MAX[7:0];
		end else begin
			reading = dec_wide[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			best_q <= asc_pkg::SCORE_MIN;
			best_idx_q <= '0;
			drop_q <= 1'b0;
			rd_idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
							if (count_q == '0 || logit > best_q) begin
								best_q <= logit;
								best_idx_q <= count_q[asc_pkg::IDX_W-1:0];
							end
						end
						if (s_tlast) begin
							rd_idx_q <= '0;
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_START;
				end
				ST_START: begin
					state_q <= ST_TERM;
				end
				ST_TERM: begin
					if (exp_done) begin
						if (rd_idx_q + 1'b1 == count_q) begin
							state_q <= ST_DIVGO;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						count_q <= '0;
						best_q <= asc_pkg::SCORE_MIN;
						best_idx_q <= '0;
						drop_q <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ && rd_idx_q == '0) begin
			sum_q <= '0;
		end else if (state_q == ST_TERM && exp_done) begin
			sum_q <= sum_q + asc_pkg::SUM_W'(term);
		end
		if (state_q == ST_DIV && div_done) begin
			conf_q <= div_conf;
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {7'b0, drop_q, reading, is_dec, conf_q, best_idx_q[6:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

>>> src/asc_checker.sv
`timescale 1ns / 1ps
module asc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result request withdrawn before it was taken.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Result changed while stalled.");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("Input taken while the vector is being evaluated.");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:33] == 7'b0)
		else $error("Result padding bits are not zero.");

	a_percent_reading: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[23] |-> m_tdata[31:24] == {1'b0, m_tdata[6:0]})
		else $error("Percentage reading differs from the class index.");

endmodule

bind argmax_softmax_confidence asc_checker u_asc_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int RESET_CYCLES = 6;
	localparam int IDLE_PCT = 17;
	localparam int TARGET_SCORES = 1150;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 15 * asc_pkg::NUM_CLASSES + 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int EXP_LIMIT = 4096;
	localparam int EXP_TERMS = 12;
	localparam logic [63:0] EXP_SEED_Q32 = 64'd4278222805;
	localparam logic [63:0] UNIT_Q32 = 64'h1_0000_0000;
	localparam logic [63:0] ROUND_Q32 = 64'h0_8000_0000;

	typedef struct packed {
		logic [15:0] logit;
		logic        last;
	} score_req_t;

	typedef struct packed {
		logic [6:0]        class_index;
		logic [15:0]       confidence;
		logic              is_decimal;
		logic signed [7:0] reading;
		logic              overflow;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // logit
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // class_index, confidence, is_decimal, reading, overflow

	score_req_t score_q[$];
	verdict_t   verdict_q[$];

	logic signed [15:0] held_scores [asc_pkg::NUM_CLASSES];
	int                 held_count = 0;
	logic signed [15:0] peak_score = asc_pkg::SCORE_MIN;
	int                 peak_index = 0;
	bit                 spilled = 1'b0;

	int  errors = 0;
	int  scores_sent = 0;
	int  results_seen = 0;
	int  decimal_seen = 0;
	int  vectors_built = 0;
	int  overlong_built = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  cycles = 0;

	argmax_softmax_confidence dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned neg_exp_q16(input int unsigned k);
		logic [63:0] acc;
		logic [63:0] f;
		if (k >= EXP_LIMIT)
			return 0;
		acc = UNIT_Q32;
		f = EXP_SEED_Q32;
		for (int b = 0; b < EXP_TERMS; b++) begin
			if ((k >> b) & 1)
				acc = (acc * f + ROUND_Q32) >> 32;
			f = (f * f + ROUND_Q32) >> 32;
		end
		return int'((acc + 64'd32768) >> 16);
	endfunction

	task automatic absorb_score(input logic signed [15:0] x, input logic last);
		int unsigned total;
		logic [63:0] conf;
		int          rd;
		verdict_t    v;
		if (held_count < asc_pkg::NUM_CLASSES) begin
			held_scores[held_count] = x;
			if (held_count == 0 || x > peak_score) begin
				peak_score = x;
				peak_index = held_count;
			end
			held_count++;
		end else begin
			spilled = 1'b1;
		end
		if (last) begin
			total = 0;
			for (int i = 0; i < held_count; i++)
				total += neg_exp_q16(int'(peak_score) - int'(held_scores[i]));
			conf = (UNIT_Q32 + 64'(total / 2)) / 64'(total);
			if (conf > 64'd65535)
				conf = 64'd65535;
			if (peak_index > int'(asc_pkg::PERCENT_MAX)) begin
				rd = peak_index - int'(asc_pkg::DECIMAL_OFFSET);
				if (rd > int'(asc_pkg::READING_MAX))
					rd = int'(asc_pkg::READING_MAX);
			end else begin
				rd = peak_index;
			end
			v.class_index = peak_index[6:0];
			v.confidence = conf[15:0];
			v.is_decimal = (peak_index > int'(asc_pkg::PERCENT_MAX));
			v.reading = rd[7:0];
			v.overflow = spilled;
			verdict_q = {verdict_q, v};
			held_count = 0;
			peak_score = asc_pkg::SCORE_MIN;
			peak_index = 0;
			spilled = 1'b0;
		end
	endtask

	task automatic push_score(input int v, input bit last);
		score_req_t r;
		r.logit = v[15:0];
		r.last = last;
		score_q = {score_q, r};
		if (last)
			vectors_built++;
	endtask

	task automatic add_vector(input int n, input int peak);
		int base;
		int v;
		int prev;
		int style;
		base = $urandom_range(0, 52767) - 20000;
		style = $urandom_range(0, 3);
		prev = base;
		if (n > asc_pkg::NUM_CLASSES)
			overlong_built++;
		for (int i = 0; i < n; i++) begin
			if (peak >= 0) begin
				v = (i == peak) ? base : base - int'($urandom_range(1, 3000));
			end else begin
				case (style)
					0: v = int'($urandom_range(0, 65535)) - 32768;
					1: v = base - int'($urandom_range(0, 4200));
					2: begin
						case ($urandom_range(0, 4))
							0: v = 32767;
							1: v = -32768;
							2: v = 0;
							3: v = -1;
							default: v = base;
						endcase
					end
					default: v = ($urandom_range(0, 2) == 0) ? prev
						: base - int'($urandom_range(0, 600));
				endcase
			end
			if (v < -32768)
				v = -32768;
			prev = v;
			push_score(v, i == n - 1);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Sender: each accepted request is fed to the predictor before the next one is offered.
	always @(posedge clk) begin
		logic       nv;
		logic [15:0] nd;
		logic       nl;
		score_req_t item;
		if (arst_n) begin
			nv = s_tvalid;
			nd = s_tdata;
			nl = s_tlast;
			if (s_tvalid && s_tready) begin
				absorb_score(s_tdata, s_tlast);
				scores_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (score_q.size() != 0 && ((scores_sent >= 300 && scores_sent < 500)
					|| $urandom_range(0, 99) >= IDLE_PCT)) begin
					item = score_q.pop_front();
					nv = 1'b1;
					nd = item.logit;
					nl = item.last;
				end else begin
					nv = 1'b0;
				end
			end
			s_tvalid <= nv;
			s_tdata <= nd;
			s_tlast <= nl;
		end
	end

	// Receiver: one long hold-off early on makes the block back up onto its input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && results_seen == 4 && m_tvalid) begin
				m_tready <= 1'b0;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				m_tready <= (results_seen >= 20 && results_seen < 35)
					|| ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.class_index = m_tdata[6:0];
			got.confidence = m_tdata[22:7];
			got.is_decimal = m_tdata[23];
			got.reading = m_tdata[31:24];
			got.overflow = m_tdata[32];
			results_seen <= results_seen + 1;
			if (verdict_q.size() == 0) begin
				$display("%0t: result with nothing predicted, expected none, actual %h",
					$time, m_tdata);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (want.is_decimal)
					decimal_seen++;
				check_field("class_index", want.class_index, got.class_index);
				check_field("confidence", want.confidence, got.confidence);
				check_field("is_decimal", want.is_decimal, got.is_decimal);
				check_field("reading", want.reading, got.reading);
				check_field("overflow", want.overflow, got.overflow);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("argmax_softmax_confidence regression: fail");
			$finish;
		end
	end

	initial begin
		int r;
		push_score(0, 1);
		push_score(32767, 0);
		push_score(-32768, 1);
		push_score(-32768, 0);
		push_score(-32768, 1);
		push_score(5, 0);
		push_score(5, 0);
		push_score(5, 1);
		push_score(-32768, 0);
		push_score(100, 0);
		push_score(100, 0);
		push_score(-5, 1);
		push_score(256, 0);
		push_score(0, 1);
		push_score(4095, 0);
		push_score(0, 1);
		push_score(4096, 0);
		push_score(0, 1);
		// Peaks either side of the percentage/decimal boundary, at the top of the store,
		// and vectors that run past the store depth.
		add_vector(101, 100);
		add_vector(102, 101);
		add_vector(asc_pkg::NUM_CLASSES, asc_pkg::NUM_CLASSES - 1);
		add_vector(asc_pkg::NUM_CLASSES + 7, 110);
		add_vector(asc_pkg::NUM_CLASSES + 1, -1);
		while (score_q.size() < TARGET_SCORES) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				add_vector($urandom_range(1, 10), -1);
			else if (r < 92)
				add_vector($urandom_range(11, 60), -1);
			else if (r < 97)
				add_vector($urandom_range(101, asc_pkg::NUM_CLASSES),
					$urandom_range(90, 100));
			else
				add_vector($urandom_range(asc_pkg::NUM_CLASSES + 1,
					asc_pkg::NUM_CLASSES + 12), -1);
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		while (score_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Streamed %0d scores in %0d vectors, %0d of them longer than the store.",
			scores_sent, vectors_built, overlong_built);
		$display("Checked %0d results, %0d with a decimal class, in %0d cycles.",
			results_seen, decimal_seen, cycles);
		if (errors == 0) begin
			$display("argmax_softmax_confidence regression: pass");
		end else begin
			$display("argmax_softmax_confidence regression: fail");
		end
		$finish;
	end

endmodule

>>> argmax_softmax_confidence.f
src/asc_pkg.sv
src/asc_score_store.sv
src/asc_exp_unit.sv
src/asc_divider.sv
src/argmax_softmax_confidence.sv
src/asc_checker.sv
dv/testbench.sv
